// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// shared types, constants and helpers for the context slot pool
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  // pool geometry
  localparam int NumSlots      = 64;
  localparam int NumCpus       = 16;
  localparam int MaxCpuCount   = 16;
  localparam int SlotsPerCpu   = 4;
  localparam int SlotW         = $clog2(NumSlots);
  localparam int CpuW          = $clog2(NumCpus);
  localparam int CntW          = SlotW + 1;
  localparam int CfgW          = 5;
  localparam int ProdW         = CfgW + 5;
  localparam int ActiveCpusRst = 16;

  // free slot search, slots looked at per cycle
  localparam int ScanGroup     = 8;
  localparam int NumGroups     = NumSlots / ScanGroup;
  localparam int GrpW          = (NumGroups > 1) ? $clog2(NumGroups) : 1;

  typedef enum logic [2:0] {
    OpReserve = 3'd0,
    OpSeal    = 3'd1,
    OpFind    = 3'd2,
    OpRelease = 3'd3,
    OpSetNext = 3'd4,
    OpRead    = 3'd5
  } csp_op_e;

  typedef enum logic [2:0] {
    RcSuccess  = 3'd0,
    RcBusy     = 3'd1,
    RcBlocked  = 3'd2,
    RcNotFound = 3'd3,
    RcUsage    = 3'd4
  } csp_status_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StScan,
    StRead
  } csp_state_e;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [CpuW-1:0] cpu_id;
    logic [63:0]     command;
    logic [63:0]     transfer;
    logic            cancel_allowed;
    logic            contiguous;
    logic [5:0]      handle;
    logic [31:0]     next_fid;
  } csp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [63:0] ctx_command;
    logic [63:0] ctx_transfer;
    logic        ctx_cancel_allowed;
    logic        ctx_contiguous;
    logic [31:0] ctx_expected_fid;
  } csp_rsp_t;

  // per-slot context words kept in the context ram
  typedef struct packed {
    logic [63:0] command;
    logic [63:0] transfer;
    logic        contiguous;
    logic        cancel_allowed;
  } csp_ctx_t;

  // outcome of the free slot search
  typedef struct packed {
    logic             done;
    logic             found;
    logic             blocked;
    logic [SlotW-1:0] slot;
  } csp_scan_t;

  // response with slot zeroed on any non-success status
  function automatic csp_rsp_t csp_mk_rsp(csp_status_e st, logic [SlotW-1:0] sl);
    csp_rsp_t r;
    r        = '0;
    r.status = st;
    r.slot   = (st == RcSuccess) ? sl : '0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csp_ram.sv =====
// ----------------------------------------------------------------------------
// csp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module csp_ram #(
  parameter int  Width = 8,
  parameter int  Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csp_scan.sv =====
// ----------------------------------------------------------------------------
// csp_scan
// free slot search, one group of slots per cycle while run_i is high, lowest index first
// ----------------------------------------------------------------------------
`default_nettype none

module csp_scan (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         run_i,
  input  wire logic [csp_pkg::NumSlots-1:0] free_i,
  input  wire logic [csp_pkg::NumSlots-1:0] resv_i,
  input  wire logic [csp_pkg::CntW-1:0]     n_i,
  output csp_pkg::csp_scan_t                res_o
);

  import csp_pkg::*;

  logic [GrpW-1:0]  grp_q, grp_d;
  logic             seen_q, seen_d;
  logic             found;
  logic [SlotW-1:0] fslot;
  logic             resv_here;
  logic             last;

  // lowest in-range free slot of the current group
  always_comb begin
    found     = 1'b0;
    fslot     = '0;
    resv_here = 1'b0;
    for (int j = ScanGroup - 1; j >= 0; j--) begin
      if ((int'(grp_q) * ScanGroup + j) < int'(n_i)) begin
        if (free_i[SlotW'(int'(grp_q) * ScanGroup + j)]) begin
          found = 1'b1;
          fslot = SlotW'(int'(grp_q) * ScanGroup + j);
        end
        if (resv_i[SlotW'(int'(grp_q) * ScanGroup + j)]) begin
          resv_here = 1'b1;
        end
      end
    end
  end

  assign last = ((int'(grp_q) + 1) * ScanGroup >= int'(n_i)) ||
                (int'(grp_q) == NumGroups - 1);

  always_comb begin
    res_o.done    = found || last;
    res_o.found   = found;
    res_o.slot    = fslot;
    // nothing free and nothing reserved: every active slot is sealed
    res_o.blocked = !(seen_q || resv_here);
  end

  always_comb begin
    grp_d  = grp_q;
    seen_d = seen_q;
    if (start_i) begin
      grp_d  = '0;
      seen_d = 1'b0;
    end else if (run_i && !res_o.done) begin
      grp_d  = grp_q + GrpW'(1);
      seen_d = seen_q || resv_here;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      grp_q  <= grp_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/context_slot_pool_core.sv =====
// ----------------------------------------------------------------------------
// context_slot_pool_core
// pool of operation-context slots bound to cpus, with per-slot context ram
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown on rsp_o for one cycle with result_valid_o high, and the
// receiver cannot stall it. Seal, find, release, set-next-command and all
// error cases go from idle through the exec state back to idle; read context
// adds the read state because the context rams have registered read data;
// reserve adds the scan state, which searches 8-slot groups for a free slot
// one group at a time (1 to 8 groups). Slot status and cpu bindings live
// in flops and reset to free and unbound at once, so no clearing pass is
// needed; context words live in two rams (context and expected function id)
// that are written by reserve before any cpu can read them. The active cpu
// register may be written only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module context_slot_pool_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request transaction
  input  wire logic                     start,
  output logic                          busy,
  input  wire csp_pkg::csp_req_t        req_i,
  // result transaction
  output logic                          result_valid_o,
  output csp_pkg::csp_rsp_t             rsp_o,
  // active cpu register write
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [csp_pkg::CfgW-1:0] cfg_wdata_i
);

  import csp_pkg::*;

  localparam int CtxW = $bits(csp_ctx_t);

  // fsm and request hold
  csp_state_e       state_q, state_d;
  csp_req_t         req_q;

  // result register
  csp_rsp_t         rsp_q, rsp_d;
  logic             rvalid_q, rvalid_d;

  // active cpu count
  logic [CfgW-1:0]  cfg_q;

  // slot status: free when neither bit is set
  logic [NumSlots-1:0] resv_q, resv_d;
  logic [NumSlots-1:0] seal_q, seal_d;

  // cpu bindings
  logic [NumCpus-1:0]  bound_q, bound_d;
  logic [SlotW-1:0]    cslot_q [NumCpus];
  logic [SlotW-1:0]    cslot_d [NumCpus];

  // derived request info
  logic [CfgW-1:0]  cpus_eff;
  logic [ProdW-1:0] prod;
  logic [CntW-1:0]  n_act;
  logic             cpu_ok;
  logic             cur_bound;
  logic [SlotW-1:0] cur_slot;
  logic             cur_free;
  logic             handle_ok;
  logic [SlotW-1:0] hnd;

  // search unit
  logic             scan_start;
  csp_scan_t        scan;

  // ram ports
  logic             ctx_we;
  logic             fid_we;
  logic [SlotW-1:0] ctx_waddr;
  logic [SlotW-1:0] fid_waddr;
  logic [31:0]      fid_wdata;
  csp_ctx_t         ctx_wdata;
  logic             ram_re;
  logic [CtxW-1:0]  ctx_rdata;
  logic [31:0]      fid_rdata;
  csp_ctx_t         ctx_rd;

  // active slot count: min(active cpus, max cpus) times slots per cpu, capped
  assign cpus_eff = (int'(cfg_q) > MaxCpuCount) ? CfgW'(MaxCpuCount) : cfg_q;
  assign prod     = ProdW'(cpus_eff) * ProdW'(SlotsPerCpu);
  assign n_act    = (prod > ProdW'(NumSlots)) ? CntW'(NumSlots) : prod[CntW-1:0];

  // lookups for the held request
  assign cpu_ok    = int'(req_q.cpu_id) < MaxCpuCount;
  assign cur_bound = bound_q[req_q.cpu_id];
  assign cur_slot  = cslot_q[req_q.cpu_id];
  assign cur_free  = !resv_q[cur_slot] && !seal_q[cur_slot];
  assign hnd       = req_q.handle[SlotW-1:0];
  assign handle_ok = {1'b0, hnd} < n_act;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  csp_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .run_i   (state_q == StScan),
    .free_i  (~(resv_q | seal_q)),
    .resv_i  (resv_q),
    .n_i     (n_act),
    .res_o   (scan)
  );

  // context words written only by reserve
  assign ctx_waddr                = scan.slot;
  assign ctx_wdata.command        = req_q.command;
  assign ctx_wdata.transfer       = req_q.transfer;
  assign ctx_wdata.contiguous     = req_q.contiguous;
  assign ctx_wdata.cancel_allowed = req_q.cancel_allowed;

  csp_ram #(
    .Width (CtxW),
    .Depth (NumSlots)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ctx_we),
    .waddr_i (ctx_waddr),
    .wdata_i (ctx_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_slot),
    .rdata_o (ctx_rdata)
  );

  // expected function id, cleared by reserve, written by set next command
  csp_ram #(
    .Width (32),
    .Depth (NumSlots)
  ) u_fid_ram (
    .clk_i   (clk_i),
    .we_i    (fid_we),
    .waddr_i (fid_waddr),
    .wdata_i (fid_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_slot),
    .rdata_o (fid_rdata)
  );

  assign ctx_rd = csp_ctx_t'(ctx_rdata);

  // next state and slot updates
  always_comb begin
    state_d    = state_q;
    rsp_d      = rsp_q;
    rvalid_d   = 1'b0;
    resv_d     = resv_q;
    seal_d     = seal_q;
    bound_d    = bound_q;
    cslot_d    = cslot_q;
    scan_start = 1'b0;
    ctx_we     = 1'b0;
    fid_we     = 1'b0;
    fid_waddr  = cur_slot;
    fid_wdata  = req_q.next_fid;
    ram_re     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StExec;
        end
      end

      StExec: begin
        // usage error unless an arm below says otherwise
        state_d  = StIdle;
        rvalid_d = 1'b1;
        rsp_d    = csp_mk_rsp(RcUsage, '0);
        if (cpu_ok) begin
          unique case (csp_op_e'(req_q.opcode))
            OpReserve: begin
              if (!cur_bound) begin
                rvalid_d   = 1'b0;
                scan_start = 1'b1;
                state_d    = StScan;
              end
            end
            OpSeal: begin
              if (cur_bound && !cur_free) begin
                seal_d[cur_slot]      = 1'b1;
                resv_d[cur_slot]      = 1'b0;
                bound_d[req_q.cpu_id] = 1'b0;
                rsp_d                 = csp_mk_rsp(RcSuccess, cur_slot);
              end
            end
            OpFind: begin
              if (!handle_ok || !seal_q[hnd]) begin
                rsp_d = csp_mk_rsp(RcNotFound, '0);
              end else begin
                // an existing binding is simply replaced
                seal_d[hnd]           = 1'b0;
                resv_d[hnd]           = 1'b1;
                bound_d[req_q.cpu_id] = 1'b1;
                cslot_d[req_q.cpu_id] = hnd;
                rsp_d                 = csp_mk_rsp(RcSuccess, hnd);
              end
            end
            OpRelease: begin
              if (cur_bound && resv_q[cur_slot]) begin
                resv_d[cur_slot]      = 1'b0;
                bound_d[req_q.cpu_id] = 1'b0;
                rsp_d                 = csp_mk_rsp(RcSuccess, cur_slot);
              end
            end
            OpSetNext: begin
              if (cur_bound) begin
                fid_we = 1'b1;
                rsp_d  = csp_mk_rsp(RcSuccess, cur_slot);
              end
            end
            OpRead: begin
              if (cur_bound) begin
                ram_re   = 1'b1;
                rvalid_d = 1'b0;
                state_d  = StRead;
              end
            end
            default: begin
              rsp_d = csp_mk_rsp(RcUsage, '0);
            end
          endcase
        end
      end

      StScan: begin
        if (scan.done) begin
          state_d  = StIdle;
          rvalid_d = 1'b1;
          if (scan.found) begin
            // claim the slot, store request words, clear the function id
            resv_d[scan.slot]     = 1'b1;
            bound_d[req_q.cpu_id] = 1'b1;
            cslot_d[req_q.cpu_id] = scan.slot;
            ctx_we                = 1'b1;
            fid_we                = 1'b1;
            fid_waddr             = scan.slot;
            fid_wdata             = '0;
            rsp_d                 = csp_mk_rsp(RcSuccess, scan.slot);
          end else if (scan.blocked) begin
            rsp_d = csp_mk_rsp(RcBlocked, '0);
          end else begin
            rsp_d = csp_mk_rsp(RcBusy, '0);
          end
        end
      end

      StRead: begin
        state_d                  = StIdle;
        rvalid_d                 = 1'b1;
        rsp_d                    = csp_mk_rsp(RcSuccess, cur_slot);
        rsp_d.ctx_command        = ctx_rd.command;
        rsp_d.ctx_transfer       = ctx_rd.transfer;
        rsp_d.ctx_cancel_allowed = ctx_rd.cancel_allowed;
        rsp_d.ctx_contiguous     = ctx_rd.contiguous;
        rsp_d.ctx_expected_fid   = fid_rdata;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rvalid_q <= 1'b0;
      cfg_q    <= CfgW'(ActiveCpusRst);
      resv_q   <= '0;
      seal_q   <= '0;
      bound_q  <= '0;
      cslot_q  <= '{default: '0};
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      resv_q   <= resv_d;
      seal_q   <= seal_d;
      bound_q  <= bound_d;
      cslot_q  <= cslot_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  assign result_valid_o = rvalid_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire
